FILE: hdl/pcrd_pkg.sv
// ----------------------------------------------------------------------------
// pcrd_pkg: shared types and constants for the primary ray direction block
// Payload structs, register indexes, reset values and pipeline depths.
// ----------------------------------------------------------------------------
package pcrd_pkg;

	localparam int FRAC_BITS  = 14;
	localparam int EXT_BITS   = 8;
	localparam int MAX_DIM    = 4096;
	localparam int PIX_W      = 12;
	localparam int DIM_W      = 13;
	localparam int COMP_W     = 16;
	localparam int VEC_W      = 3 * COMP_W;
	localparam int SCL_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = VEC_W;

	// divide by 16*W or 16*H: numerator, divisor, quotient, remainder
	localparam int NUM_W   = 47;
	localparam int DEN_W   = DIM_W + 4;
	localparam int QUO_W   = 28;
	localparam int REM_W   = DEN_W;
	localparam int DIV_LAT = QUO_W;

	// integer square root of the squared length
	localparam int SUM_W    = 60;
	localparam int ROOT_W   = SUM_W / 2;
	localparam int SREM_W   = ROOT_W + 2;
	localparam int SQRT_LAT = ROOT_W;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORWARD      = 3'd0,
		REG_RIGHT        = 3'd1,
		REG_UP           = 3'd2,
		REG_HALF_WIDTH   = 3'd3,
		REG_HALF_HEIGHT  = 3'd4,
		REG_FRAME_WIDTH  = 3'd5,
		REG_FRAME_HEIGHT = 3'd6
	} cfg_reg_t;

	localparam logic [VEC_W-1:0] FORWARD_RST = 48'h0000_0000_4000;
	localparam logic [VEC_W-1:0] RIGHT_RST   = 48'h4000_0000_0000;
	localparam logic [VEC_W-1:0] UP_RST      = 48'h0000_4000_0000;
	localparam logic [SCL_W-1:0] HALF_W_RST  = 16'd4096;
	localparam logic [SCL_W-1:0] HALF_H_RST  = 16'd3072;
	localparam logic [DIM_W-1:0] FRAME_W_RST = 13'd640;
	localparam logic [DIM_W-1:0] FRAME_H_RST = 13'd480;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] dir_x;
		logic signed [COMP_W-1:0] dir_y;
		logic signed [COMP_W-1:0] dir_z;
		logic                     out_of_frame;
	} ray_t;

endpackage

FILE: hdl/pcrd_div.sv
// ----------------------------------------------------------------------------
// pcrd_div: pipelined restoring divider
// One quotient bit per stage; the divisor is static config and is not staged.
// ----------------------------------------------------------------------------
module pcrd_div
	import pcrd_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quot
);

	logic [REM_W-1:0] rem_s [DIV_LAT];
	logic [QUO_W-1:0] lo_s  [DIV_LAT];
	logic [QUO_W-1:0] quo_s [DIV_LAT];
	logic [REM_W-1:0] rem_d [DIV_LAT];
	logic [QUO_W-1:0] lo_d  [DIV_LAT];
	logic [QUO_W-1:0] quo_d [DIV_LAT];

	// one shift-compare-subtract per stage
	always_comb begin
		logic [REM_W-1:0] r;
		logic [QUO_W-1:0] lo;
		logic [QUO_W-1:0] qu;
		logic [REM_W:0]   t;
		for (int k = 0; k < DIV_LAT; k++) begin
			if (k == 0) begin
				// top bits are below the divisor for any in-frame pixel
				r  = num[QUO_W+REM_W-1:QUO_W];
				lo = num[QUO_W-1:0];
				qu = '0;
			end else begin
				r  = rem_s[k-1];
				lo = lo_s[k-1];
				qu = quo_s[k-1];
			end
			t = {r, lo[QUO_W-1]};
			if (t >= {1'b0, den}) begin
				rem_d[k] = REM_W'(t - {1'b0, den});
				quo_d[k] = {qu[QUO_W-2:0], 1'b1};
			end else begin
				rem_d[k] = t[REM_W-1:0];
				quo_d[k] = {qu[QUO_W-2:0], 1'b0};
			end
			lo_d[k] = {lo[QUO_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				rem_s[k] <= rem_d[k];
				lo_s[k]  <= lo_d[k];
				quo_s[k] <= quo_d[k];
			end
		end
	end

	assign quot = quo_s[DIV_LAT-1];

endmodule

FILE: hdl/pcrd_isqrt.sv
// ----------------------------------------------------------------------------
// pcrd_isqrt: pipelined floor integer square root
// Digit-by-digit method, one root bit per stage.
// ----------------------------------------------------------------------------
module pcrd_isqrt
	import pcrd_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [SUM_W-1:0]  sum,
	output logic [ROOT_W-1:0] root
);

	logic [SREM_W-1:0] rem_s  [SQRT_LAT];
	logic [ROOT_W-1:0] root_s [SQRT_LAT];
	logic [SUM_W-1:0]  lo_s   [SQRT_LAT];
	logic [SREM_W-1:0] rem_d  [SQRT_LAT];
	logic [ROOT_W-1:0] root_d [SQRT_LAT];
	logic [SUM_W-1:0]  lo_d   [SQRT_LAT];

	// bring down two bits, try 4*root+1
	always_comb begin
		logic [SREM_W-1:0] r;
		logic [ROOT_W-1:0] rt;
		logic [SUM_W-1:0]  lo;
		logic [SREM_W+1:0] t;
		logic [SREM_W+1:0] trial;
		for (int k = 0; k < SQRT_LAT; k++) begin
			if (k == 0) begin
				r  = '0;
				rt = '0;
				lo = sum;
			end else begin
				r  = rem_s[k-1];
				rt = root_s[k-1];
				lo = lo_s[k-1];
			end
			t     = {r, lo[SUM_W-1:SUM_W-2]};
			trial = {2'b00, rt, 2'b01};
			if (t >= trial) begin
				rem_d[k]  = SREM_W'(t - trial);
				root_d[k] = {rt[ROOT_W-2:0], 1'b1};
			end else begin
				rem_d[k]  = t[SREM_W-1:0];
				root_d[k] = {rt[ROOT_W-2:0], 1'b0};
			end
			lo_d[k] = {lo[SUM_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_LAT; k++) begin
				rem_s[k]  <= rem_d[k];
				root_s[k] <= root_d[k];
				lo_s[k]   <= lo_d[k];
			end
		end
	end

	assign root = root_s[SQRT_LAT-1];

endmodule

FILE: hdl/pinhole_camera_ray_direction.sv
// ----------------------------------------------------------------------------
// pinhole_camera_ray_direction: unit primary ray direction per pixel
// Pipeline: 3 setup stages, 28 divider stages, 3 combine stages,
// 30 square root stages, 16 normalize stages and the output register.
// Throughput one item per cycle; the whole pipe holds while a result stalls.
// Reset clears valid bits and loads the default camera; payload is not reset.
// ----------------------------------------------------------------------------
module pinhole_camera_ray_direction
	import pcrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_t                  pix,
	output logic                  ray_valid,
	input  logic                  ray_stall,
	output ray_t                  ray,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NORM_LAT = FRAC_BITS + 2;
	localparam int XN_W     = 31;
	localparam int D_W      = 30;
	localparam int M_W      = D_W - 1;
	localparam int NR_W     = ROOT_W;

	typedef struct packed {
		logic       oof;
		logic [5:0] neg;
	} div_side_t;

	typedef struct packed {
		logic                oof;
		logic [2:0]          neg;
		logic [3*M_W-1:0]    m;
	} sqrt_side_t;

	typedef struct packed {
		logic              oof;
		logic [2:0]        neg;
		logic [ROOT_W-1:0] mag;
	} norm_side_t;

	// configuration registers
	logic [VEC_W-1:0] forward_q, right_q, up_q;
	logic [SCL_W-1:0] half_w_q, half_h_q;
	logic [DIM_W-1:0] frame_w_q, frame_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_q <= FORWARD_RST;
			right_q   <= RIGHT_RST;
			up_q      <= UP_RST;
			half_w_q  <= HALF_W_RST;
			half_h_q  <= HALF_H_RST;
			frame_w_q <= FRAME_W_RST;
			frame_h_q <= FRAME_H_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FORWARD:      forward_q <= cfg_data;
				REG_RIGHT:        right_q   <= cfg_data;
				REG_UP:           up_q      <= cfg_data;
				REG_HALF_WIDTH:   half_w_q  <= cfg_data[SCL_W-1:0];
				REG_HALF_HEIGHT:  half_h_q  <= cfg_data[SCL_W-1:0];
				REG_FRAME_WIDTH:  frame_w_q <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_h_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped frame size and unpacked basis vectors
	logic [DIM_W-1:0]         w, h;
	logic signed [COMP_W-1:0] fwd [3];
	logic signed [COMP_W-1:0] bas [6];

	assign w = (frame_w_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_w_q;
	assign h = (frame_h_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_h_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fwd[c]   = forward_q[VEC_W-1-COMP_W*c -: COMP_W];
			bas[c]   = right_q[VEC_W-1-COMP_W*c -: COMP_W];
			bas[c+3] = up_q[VEC_W-1-COMP_W*c -: COMP_W];
		end
	end

	// whole-pipe advance
	logic en;
	assign en        = !ray_valid || !ray_stall;
	assign pix_stall = !en;

	// stage 1: frame test and scaled pixel offsets
	logic                   v_s1, oof_s1;
	logic signed [XN_W-1:0] xn_s1, yn_s1;
	logic signed [13:0]     ax, ay;
	logic signed [SCL_W:0]  hws, hhs;

	assign ax  = $signed({1'b0, pix.pixel_x, 1'b1}) - $signed({1'b0, w});
	assign ay  = $signed({1'b0, pix.pixel_y, 1'b1}) - $signed({1'b0, h});
	assign hws = $signed({1'b0, half_w_q});
	assign hhs = $signed({1'b0, half_h_q});

	always_ff @(posedge clk) begin
		if (en) begin
			oof_s1 <= (w == '0) || (h == '0) || ({1'b0, pix.pixel_x} >= w)
				|| ({1'b0, pix.pixel_y} >= h);
			xn_s1  <= ax * hws;
			yn_s1  <= ay * hhs;
		end
	end

	// stage 2: offset times basis component
	logic                    v_s2, oof_s2;
	logic signed [NUM_W-1:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			oof_s2 <= oof_s1;
			for (int l = 0; l < 3; l++) begin
				p_s2[l]   <= xn_s1 * bas[l];
				p_s2[l+3] <= yn_s1 * bas[l+3];
			end
		end
	end

	// stage 3: magnitude plus half divisor for rounding
	logic             v_s3, oof_s3;
	logic [5:0]       neg_s3;
	logic [NUM_W-1:0] num_s3 [6];
	logic [DEN_W-1:0] den_x, den_y;

	assign den_x = {w, 4'b0000};
	assign den_y = {h, 4'b0000};

	always_ff @(posedge clk) begin
		if (en) begin
			oof_s3 <= oof_s2;
			for (int l = 0; l < 6; l++) begin
				neg_s3[l] <= p_s2[l][NUM_W-1];
				num_s3[l] <= (p_s2[l][NUM_W-1] ? NUM_W'(-p_s2[l]) : NUM_W'(p_s2[l]))
					+ NUM_W'((l < 3) ? {w, 3'b000} : {h, 3'b000});
			end
		end
	end

	// six dividers
	logic [QUO_W-1:0] quot [6];

	for (genvar l = 0; l < 6; l++) begin : g_div
		pcrd_div u_div (
			.clk  (clk),
			.en   (en),
			.num  (num_s3[l]),
			.den  ((l < 3) ? den_x : den_y),
			.quot (quot[l])
		);
	end

	// item tags alongside the dividers
	logic      v_dv [DIV_LAT];
	div_side_t sd_dv [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			sd_dv[0] <= '{oof: oof_s3, neg: neg_s3};
			for (int k = 1; k < DIV_LAT; k++) sd_dv[k] <= sd_dv[k-1];
		end
	end

	// stage 4: direction components on the fine grid
	logic                v_s4, oof_s4;
	logic signed [D_W-1:0] d_s4 [3];

	always_ff @(posedge clk) begin
		logic signed [D_W-1:0] tx, ty;
		if (en) begin
			oof_s4 <= sd_dv[DIV_LAT-1].oof;
			for (int c = 0; c < 3; c++) begin
				tx = $signed({2'b00, quot[c]});
				ty = $signed({2'b00, quot[c+3]});
				if (sd_dv[DIV_LAT-1].neg[c])   tx = -tx;
				if (sd_dv[DIV_LAT-1].neg[c+3]) ty = -ty;
				d_s4[c] <= tx + ty + (D_W'(fwd[c]) <<< EXT_BITS);
			end
		end
	end

	// stage 5: magnitudes and squares
	logic                v_s5, oof_s5;
	logic [2:0]          neg_s5;
	logic [M_W-1:0]      m_s5  [3];
	logic [2*M_W-1:0]    sq_s5 [3];

	always_ff @(posedge clk) begin
		logic [M_W-1:0] mg;
		if (en) begin
			oof_s5 <= oof_s4;
			for (int c = 0; c < 3; c++) begin
				mg         = d_s4[c][D_W-1] ? M_W'(-d_s4[c]) : M_W'(d_s4[c]);
				neg_s5[c] <= d_s4[c][D_W-1];
				m_s5[c]   <= mg;
				sq_s5[c]  <= mg * mg;
			end
		end
	end

	// stage 6: sum of squares
	logic             v_s6;
	logic [SUM_W-1:0] s_s6;
	sqrt_side_t       sd_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s6      <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
			sd_s6.oof <= oof_s5;
			sd_s6.neg <= neg_s5;
			sd_s6.m   <= {m_s5[0], m_s5[1], m_s5[2]};
		end
	end

	// length
	logic [ROOT_W-1:0] mag;

	pcrd_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.sum  (s_s6),
		.root (mag)
	);

	logic       v_sq  [SQRT_LAT];
	sqrt_side_t sd_sq [SQRT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			sd_sq[0] <= sd_s6;
			for (int k = 1; k < SQRT_LAT; k++) sd_sq[k] <= sd_sq[k-1];
		end
	end

	// normalize: floor(m * 2^15 / mag), one bit per stage, three lanes
	logic [NR_W-1:0]     nrem_s [3][NORM_LAT];
	logic [NORM_LAT-1:0] nlo_s  [3][NORM_LAT];
	logic [NORM_LAT-1:0] nq_s   [3][NORM_LAT];
	logic                v_nm   [NORM_LAT];
	norm_side_t          sd_nm  [NORM_LAT];
	logic [M_W-1:0]      m_in   [3];

	assign m_in[0] = sd_sq[SQRT_LAT-1].m[3*M_W-1:2*M_W];
	assign m_in[1] = sd_sq[SQRT_LAT-1].m[2*M_W-1:M_W];
	assign m_in[2] = sd_sq[SQRT_LAT-1].m[M_W-1:0];

	always_ff @(posedge clk) begin
		logic [NR_W-1:0]     r;
		logic [NORM_LAT-1:0] lo, qu;
		logic [NR_W:0]       t;
		logic [ROOT_W-1:0]   dv;
		if (en) begin
			sd_nm[0] <= '{oof: sd_sq[SQRT_LAT-1].oof, neg: sd_sq[SQRT_LAT-1].neg, mag: mag};
			for (int k = 1; k < NORM_LAT; k++) sd_nm[k] <= sd_nm[k-1];
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < NORM_LAT; k++) begin
					if (k == 0) begin
						r  = NR_W'(m_in[c][M_W-1:1]);
						lo = {m_in[c][0], {(NORM_LAT-1){1'b0}}};
						qu = '0;
						dv = mag;
					end else begin
						r  = nrem_s[c][k-1];
						lo = nlo_s[c][k-1];
						qu = nq_s[c][k-1];
						dv = sd_nm[k-1].mag;
					end
					t = {r, lo[NORM_LAT-1]};
					if (t >= {1'b0, dv}) begin
						nrem_s[c][k] <= NR_W'(t - {1'b0, dv});
						nq_s[c][k]   <= {qu[NORM_LAT-2:0], 1'b1};
					end else begin
						nrem_s[c][k] <= t[NR_W-1:0];
						nq_s[c][k]   <= {qu[NORM_LAT-2:0], 1'b0};
					end
					nlo_s[c][k] <= {lo[NORM_LAT-2:0], 1'b0};
				end
			end
		end
	end

	// valid bits for every stage
	logic ray_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++)  v_dv[k] <= 1'b0;
			for (int k = 0; k < SQRT_LAT; k++) v_sq[k] <= 1'b0;
			for (int k = 0; k < NORM_LAT; k++) v_nm[k] <= 1'b0;
			ray_valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= pix_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_dv[0] <= v_s3;
			for (int k = 1; k < DIV_LAT; k++) v_dv[k] <= v_dv[k-1];
			v_s4    <= v_dv[DIV_LAT-1];
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_sq[0] <= v_s6;
			for (int k = 1; k < SQRT_LAT; k++) v_sq[k] <= v_sq[k-1];
			v_nm[0] <= v_sq[SQRT_LAT-1];
			for (int k = 1; k < NORM_LAT; k++) v_nm[k] <= v_nm[k-1];
			ray_valid_q <= v_nm[NORM_LAT-1];
		end
	end

	// output: round, clamp, sign, zero for empty or out-of-frame
	ray_t ray_q;

	always_ff @(posedge clk) begin
		logic [NORM_LAT:0]          qs;
		logic [COMP_W-1:0]          qr;
		logic signed [COMP_W-1:0]   dv [3];
		norm_side_t                 sd;
		sd = sd_nm[NORM_LAT-1];
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				qs = {1'b0, nq_s[c][NORM_LAT-1]} + 1'b1;
				qr = COMP_W'(qs[NORM_LAT:1]);
				if (qr > COMP_W'(1 << FRAC_BITS)) qr = COMP_W'(1 << FRAC_BITS);
				dv[c] = sd.neg[c] ? -$signed(qr) : $signed(qr);
				if (sd.oof || (sd.mag == '0)) dv[c] = '0;
			end
			ray_q.dir_x        <= dv[0];
			ray_q.dir_y        <= dv[1];
			ray_q.dir_z        <= dv[2];
			ray_q.out_of_frame <= sd.oof;
		end
	end

	assign ray_valid = ray_valid_q;
	assign ray       = ray_q;

endmodule

FILE: hdl/pcrd_chk.sv
// ----------------------------------------------------------------------------
// pcrd_chk: port-level checks for the primary ray direction block
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module pcrd_chk
	import pcrd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pix_valid,
	input logic                  pix_stall,
	input pix_t                  pix,
	input logic                  ray_valid,
	input logic                  ray_stall,
	input ray_t                  ray,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid && ray_stall |=> ray_valid && $stable(ray))
		else $error("stalled result changed");

	// input only backs up behind a waiting result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> ray_valid && ray_stall)
		else $error("input stalled with no result waiting");

	// out-of-frame items carry a zero direction
	a_oof_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid && ray.out_of_frame |->
			ray.dir_x == '0 && ray.dir_y == '0 && ray.dir_z == '0)
		else $error("out-of-frame item with nonzero direction");

	// components stay within unit range
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid |->
			ray.dir_x <= 16'sd16384 && ray.dir_x >= -16'sd16384 &&
			ray.dir_y <= 16'sd16384 && ray.dir_y >= -16'sd16384 &&
			ray.dir_z <= 16'sd16384 && ray.dir_z >= -16'sd16384)
		else $error("direction component beyond unit");

endmodule

bind pinhole_camera_ray_direction pcrd_chk u_pcrd_chk (.*);
